// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Package of the double-ended queue unit: request and response types,
// operation and status codes, and the controller command struct. No dependencies.
package deq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ENTRY_COUNT_W = 5;

    // Operation codes carried by a request.
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 2'd3;

    // Status codes carried by a response.
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] push_value;
    } t_deq_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  pop_value;
        logic [STATUS_W-1:0]        status;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
    } t_deq_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_deq_cmd;

endpackage

// File: rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the double-ended queue unit: a three-state sequencer for the
// handshakes and the datapath commands. Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_deq_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/deq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the double-ended queue unit: slot memory, front index, entry
// count, index arithmetic and the response registers. Depends on deq_pkg.
module deq_datapath
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_deq_cmd i_cmd,
    input  t_deq_req i_req,
    output t_deq_rsp o_rsp
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    logic [VALUE_W-1:0] r_slot [DEPTH];

    logic [OPCODE_W-1:0] r_opcode;
    logic [VALUE_W-1:0]  r_push_value;
    logic [VALUE_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]    r_front;
    logic [CNT_W-1:0]    r_count;
    logic [STATUS_W-1:0] r_status;
    logic                r_pop_ok;

    logic               is_full;
    logic               is_empty;
    logic               is_push;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic [CNT_W-1:0]   offset;
    logic [SUM_W-1:0]   pos_raw;
    logic [SUM_W-1:0]   pos_wrap;
    logic [IDX_W-1:0]   back_pos;
    logic [IDX_W-1:0]   addr;
    logic               do_write;
    logic               do_read;
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_ext;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign is_push  = (r_opcode == OP_PUSH_FRONT) || (r_opcode == OP_PUSH_BACK);

    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - IDX_W'(1);
    assign front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + IDX_W'(1);

    // Push back writes one past the last entry; pop back reads the last entry.
    assign offset   = (r_opcode == OP_PUSH_BACK) ? r_count : r_count - CNT_W'(1);
    assign pos_raw  = SUM_W'(r_front) + SUM_W'(offset);
    assign pos_wrap = (pos_raw >= SUM_W'(DEPTH)) ? pos_raw - SUM_W'(DEPTH) : pos_raw;
    assign back_pos = pos_wrap[IDX_W-1:0];

    always_comb begin
        case (r_opcode)
            OP_PUSH_FRONT: addr = front_dec;
            OP_POP_FRONT:  addr = r_front;
            default:       addr = back_pos;
        endcase
    end

    assign do_write = i_cmd.execute && is_push && !is_full;
    assign do_read  = i_cmd.execute && !is_push && !is_empty;

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_slot[addr] <= r_push_value;
        end
        if (do_read) begin
            r_rd_data <= r_slot[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode     <= i_req.opcode;
            r_push_value <= i_req.push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_status <= ST_DONE;
            r_pop_ok <= 1'b0;
        end else if (i_cmd.execute) begin
            r_pop_ok <= do_read;
            if (is_push) begin
                if (is_full) begin
                    r_status <= ST_PUSH_FULL;
                end else begin
                    r_status <= ST_DONE;
                    r_count  <= r_count + CNT_W'(1);
                    if (r_opcode == OP_PUSH_FRONT) begin
                        r_front <= front_dec;
                    end
                end
            end else begin
                if (is_empty) begin
                    r_status <= ST_POP_EMPTY;
                end else begin
                    r_status <= ST_DONE;
                    r_count  <= r_count - CNT_W'(1);
                    if (r_opcode == OP_POP_FRONT) begin
                        r_front <= front_inc;
                    end
                end
            end
        end
    end

    assign count_ext = {{ENTRY_COUNT_W{1'b0}}, r_count};

    assign o_rsp.pop_value   = r_pop_ok ? r_rd_data : '0;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = count_ext[ENTRY_COUNT_W-1:0];

endmodule

// File: rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue unit: joins the controller and the
// datapath. Depends on deq_pkg, deq_ctrl and deq_datapath.
//
// Usage. A request enters on the input channel (i_in_valid, o_in_ready,
// i_in_req) and names one of four operations: push at the front, push at the
// back, pop from the front or pop from the back. Every request produces
// exactly one response on the output channel (o_out_valid, i_out_ready,
// o_out_rsp), carrying the popped word, a status code and the number of
// entries held after the request. A push to a full queue is dropped and
// reported as such; a pop from an empty queue returns zero and reports it.
// The words are kept in a ring buffer of DEPTH entries in a single-port
// memory, addressed by a front index and an entry count.
// Sequence: one request is handled at a time. It is taken in the idle state,
// executes against the memory in the execute state (one write or one
// registered read), and its response is offered in the response state until
// the receiver takes it. The memory access and the sequencer in deq_ctrl set
// this order.
// Stalls: while the receiver holds i_out_ready low the response stays on the
// port unchanged and o_in_ready stays low.
// Reset: i_rst_n is synchronous and active low; it empties the queue and
// returns the controller to waiting for a request. The memory is not cleared,
// as an entry is only ever read after it has been written.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_deq_req i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_deq_rsp o_out_rsp
);

    // Command from the sequencer to the datapath: capture a request, then
    // execute it against the ring buffer.
    t_deq_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the response registers stable until the sequencer
    // sees the response taken.
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

endmodule
